// ===== hdl/gac_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gac_pkg
// Shared types, constants and fixed-point helpers for the gripper admittance
// controller.
// ----------------------------------------------------------------------------
package gac_pkg;

    typedef enum logic [2:0] {
        REG_K_HARD    = 3'd0,
        REG_B_HARD    = 3'd1,
        REG_IM_HARD   = 3'd2,
        REG_K_SOFT    = 3'd3,
        REG_B_SOFT    = 3'd4,
        REG_IM_SOFT   = 3'd5,
        REG_TIME_STEP = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_GRIP    = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_KD,
        MS_BV,
        MS_SD,
        MS_IMF,
        MS_TA,
        MS_TV
    } mul_src_t;

    typedef logic [4:0] step_t;

    localparam step_t STEP_SETUP = 5'd0;
    localparam step_t STEP_GAIN  = 5'd1;
    localparam step_t STEP_KD    = 5'd2;
    localparam step_t STEP_BV    = 5'd3;
    localparam step_t STEP_M1    = 5'd5;
    localparam step_t STEP_SD    = 5'd6;
    localparam step_t STEP_F     = 5'd7;
    localparam step_t STEP_IMF   = 5'd8;
    localparam step_t STEP_SQ    = 5'd9;
    localparam step_t STEP_SUM   = 5'd10;
    localparam step_t STEP_TA    = 5'd11;
    localparam step_t STEP_OVER  = 5'd12;
    localparam step_t STEP_V     = 5'd14;
    localparam step_t STEP_TV    = 5'd15;
    localparam step_t STEP_GOAL  = 5'd18;
    localparam step_t STEP_DONE  = 5'd19;

    localparam logic [31:0] GAIN_ONE      = 32'h0001_0000;
    localparam logic [15:0] TIME_STEP_DEF = 16'd1311;
    localparam logic [34:0] OBJ_WIDTH_Q   = 35'd3932;
    localparam logic [31:0] TARGET_OPEN_Q = 32'd2621;
    localparam logic [38:0] HARD_RATIO    = 39'd20;
    localparam logic [63:0] THRESH_SQ     = 64'd1288490;

    typedef struct packed {
        mul_src_t iss;
        logic     ld_d;
        logic     cap_m1;
        logic     cap_sd;
        logic     cap_f;
        logic     cap_sq;
        logic     cap_v;
        logic     cap_goal;
    } lane_ctrl_t;

    typedef struct packed {
        logic cap_sum;
        logic cap_over;
        logic load;
    } merge_ctrl_t;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        mag32 = x[31] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic [34:0] sx35(input logic [31:0] x);
        sx35 = {{3{x[31]}}, x};
    endfunction

    function automatic logic [31:0] sat32(input logic [34:0] x);
        if (!x[34] && (x[33:31] != 3'b000)) begin
            sat32 = 32'h7FFF_FFFF;
        end
        else if (x[34] && (x[33:31] != 3'b111)) begin
            sat32 = 32'h8000_0000;
        end
        else begin
            sat32 = x[31:0];
        end
    endfunction

    function automatic logic [31:0] qround(input logic [63:0] p, input logic neg);
        logic [48:0] r;
        r = {1'b0, p[63:16]} + {48'd0, p[15]};
        if (r >= 49'h0_8000_0000) begin
            qround = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else begin
            qround = neg ? (~r[31:0] + 32'd1) : r[31:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/gac_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gac_lane
// Admittance step for one finger: one shared 32x32 multiplier is sequenced
// through the spring, damper, squared-force, mass and integration products.
// ----------------------------------------------------------------------------
module gac_lane
    import gac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire lane_ctrl_t  ctrl,
    input  wire logic [31:0] target,
    input  wire logic [31:0] pos,
    input  wire logic [31:0] eff,
    input  wire logic [31:0] k_gain,
    input  wire logic [31:0] b_gain,
    input  wire logic [31:0] im_gain,
    input  wire logic [15:0] t_step,
    output logic [31:0]      goal,
    output logic [31:0]      vel,
    output logic [63:0]      sq
);

    logic [31:0] d_reg;
    logic [31:0] m1_reg;
    logic [31:0] sd_reg;
    logic [31:0] f_reg;
    logic [31:0] goal_reg;
    logic [31:0] vel_reg;
    logic [63:0] sq_reg;
    logic [31:0] op_a_reg;
    logic [31:0] op_b_reg;
    logic        op_neg_reg;
    logic [63:0] prod_reg;
    logic        prod_neg_reg;
    logic [31:0] rq_reg;

    logic [31:0] op_a_next;
    logic [31:0] op_b_next;
    logic        op_neg_next;

    always_comb
    begin
        op_a_next   = '0;
        op_b_next   = '0;
        op_neg_next = 1'b0;
        unique case (ctrl.iss)
            MS_KD:
            begin
                op_a_next   = k_gain;
                op_b_next   = mag32(d_reg);
                op_neg_next = d_reg[31];
            end
            MS_BV:
            begin
                op_a_next   = b_gain;
                op_b_next   = mag32(vel_reg);
                op_neg_next = vel_reg[31];
            end
            MS_SD:
            begin
                op_a_next   = mag32(sd_reg);
                op_b_next   = mag32(sd_reg);
            end
            MS_IMF:
            begin
                op_a_next   = im_gain;
                op_b_next   = mag32(f_reg);
                op_neg_next = f_reg[31];
            end
            MS_TA:
            begin
                op_a_next   = {16'd0, t_step};
                op_b_next   = mag32(rq_reg);
                op_neg_next = rq_reg[31];
            end
            MS_TV:
            begin
                op_a_next   = {16'd0, t_step};
                op_b_next   = mag32(vel_reg);
                op_neg_next = vel_reg[31];
            end
            default:
            begin
                op_a_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_a_reg     <= op_a_next;
        op_b_reg     <= op_b_next;
        op_neg_reg   <= op_neg_next;
        prod_reg     <= op_a_reg * op_b_reg;
        prod_neg_reg <= op_neg_reg;
        rq_reg       <= qround(prod_reg, prod_neg_reg);
        if (ctrl.ld_d)
        begin
            d_reg <= sat32(sx35(pos) - sx35(target));
        end
        if (ctrl.cap_m1)
        begin
            m1_reg <= rq_reg;
        end
        if (ctrl.cap_sd)
        begin
            sd_reg <= sat32(35'd0 - sx35(m1_reg) - sx35(rq_reg));
        end
        if (ctrl.cap_f)
        begin
            f_reg <= sat32(sx35(sd_reg) - sx35(eff));
        end
        if (ctrl.cap_sq)
        begin
            sq_reg <= prod_reg;
        end
        if (ctrl.cap_goal)
        begin
            goal_reg <= sat32(sx35(pos) + sx35(rq_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg <= '0;
        end
        else if (ctrl.cap_v)
        begin
            vel_reg <= sat32(sx35(vel_reg) + sx35(rq_reg));
        end
    end

    assign goal = goal_reg;
    assign vel  = vel_reg;
    assign sq   = sq_reg;

endmodule
`default_nettype wire

// ===== hdl/gac_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gac_merge
// Combines the two finger lanes: sums the squared spring-damper forces,
// compares against the emit threshold and holds the result payload.
// ----------------------------------------------------------------------------
module gac_merge
    import gac_pkg::*;
(
    input  wire logic        clk,
    input  wire merge_ctrl_t ctrl,
    input  wire logic [63:0] sq_left,
    input  wire logic [63:0] sq_right,
    input  wire logic [31:0] goal_left,
    input  wire logic [31:0] goal_right,
    input  wire logic [31:0] speed_left,
    input  wire logic [31:0] speed_right,
    input  wire logic        hard,
    output logic             over,
    output logic [127:0]     tdata,
    output logic [0:0]       tuser
);

    logic [63:0]  sum_reg;
    logic         over_reg;
    logic [127:0] tdata_reg;
    logic [0:0]   tuser_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.cap_sum)
        begin
            sum_reg <= sq_left + sq_right;
        end
        if (ctrl.cap_over)
        begin
            over_reg <= (sum_reg > THRESH_SQ);
        end
        if (ctrl.load)
        begin
            tdata_reg <= {speed_right, speed_left, goal_right, goal_left};
            tuser_reg <= hard;
        end
    end

    assign over  = over_reg;
    assign tdata = tdata_reg;
    assign tuser = tuser_reg;

endmodule
`default_nettype wire

// ===== hdl/gripper_admittance_control_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gripper_admittance_control_top
// Admittance control of a two-finger gripper with hard/soft gain scheduling.
//
// Each slave-side transfer is one control tick: s_tuser carries the command
// (none, grip, release) and s_tdata the two finger positions and efforts.
// A grip or release command sets the target before the step. The gain set
// is chosen, then two finger lanes run the admittance step side by side,
// each sequencing six dependent products through its own 32x32 multiplier.
// A master-side transfer carries the goal positions and velocities, and
// m_tuser tells whether the hard gain set was used. A tick whose spring-
// damper force is small produces no transfer, but still updates velocities.
// A new tick is accepted only once the previous one has finished. The
// gains are written through wr_en/wr_index/wr_data while the block is
// idle; the user must keep to this, the block does not enforce it. Reset
// clears the kept velocities, selects the released target and loads the
// default gains. While a result waits for a stalled receiver, no new tick
// is taken; the result waits in the lanes until the output register is free.
// ----------------------------------------------------------------------------
module gripper_admittance_control_top
    import gac_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // position_left, position_right, effort_left, effort_right
    input  wire logic [127:0] s_tdata,
    // command
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // goal_position_left, goal_position_right, goal_velocity_left,
    // goal_velocity_right
    output logic [127:0]      m_tdata,
    // hard_gains
    output logic [0:0]        m_tuser,
    input  wire logic         wr_en,
    input  wire logic [2:0]   wr_index,
    input  wire logic [31:0]  wr_data
);

    state_t      state_reg;
    state_t      state_next;
    step_t       step_reg;
    step_t       step_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic        gripping_reg;

    logic [31:0] k_hard_reg;
    logic [31:0] b_hard_reg;
    logic [31:0] im_hard_reg;
    logic [31:0] k_soft_reg;
    logic [31:0] b_soft_reg;
    logic [31:0] im_soft_reg;
    logic [15:0] t_reg;

    logic [31:0] pos_left_reg;
    logic [31:0] pos_right_reg;
    logic [31:0] eff_left_reg;
    logic [31:0] eff_right_reg;
    logic [34:0] rem_reg;
    logic [32:0] esum_reg;
    logic        hard_reg;

    logic        accept;
    logic        cap_gain;
    logic        load;
    lane_ctrl_t  lane_ctrl;
    merge_ctrl_t merge_ctrl;
    logic [31:0] target;
    logic [31:0] k_sel;
    logic [31:0] b_sel;
    logic [31:0] im_sel;
    logic [38:0] rem20;
    logic [31:0] goal_left;
    logic [31:0] goal_right;
    logic [31:0] speed_left;
    logic [31:0] speed_right;
    logic [63:0] sq_left;
    logic [63:0] sq_right;
    logic        over;

    assign accept = s_tvalid && s_tready;
    assign target = gripping_reg ? 32'd0 : TARGET_OPEN_Q;
    assign k_sel  = hard_reg ? k_hard_reg : k_soft_reg;
    assign b_sel  = hard_reg ? b_hard_reg : b_soft_reg;
    assign im_sel = hard_reg ? im_hard_reg : im_soft_reg;
    assign rem20  = {6'd0, rem_reg[32:0]} * HARD_RATIO;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        load       = 1'b0;
        s_tready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_RUN;
                    step_next  = STEP_SETUP;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == STEP_DONE)
                begin
                    step_next = step_reg;
                    if (!over)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!m_tvalid_reg || m_tready)
                    begin
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_comb
    begin
        lane_ctrl       = '0;
        lane_ctrl.iss   = MS_NONE;
        merge_ctrl      = '0;
        merge_ctrl.load = load;
        cap_gain        = 1'b0;
        if (state_reg == ST_RUN)
        begin
            unique case (step_reg)
                STEP_SETUP: lane_ctrl.ld_d = 1'b1;
                STEP_GAIN:  cap_gain = 1'b1;
                STEP_KD:    lane_ctrl.iss = MS_KD;
                STEP_BV:    lane_ctrl.iss = MS_BV;
                STEP_M1:    lane_ctrl.cap_m1 = 1'b1;
                STEP_SD:    lane_ctrl.cap_sd = 1'b1;
                STEP_F:
                begin
                    lane_ctrl.cap_f = 1'b1;
                    lane_ctrl.iss   = MS_SD;
                end
                STEP_IMF:   lane_ctrl.iss = MS_IMF;
                STEP_SQ:    lane_ctrl.cap_sq = 1'b1;
                STEP_SUM:   merge_ctrl.cap_sum = 1'b1;
                STEP_TA:    lane_ctrl.iss = MS_TA;
                STEP_OVER:  merge_ctrl.cap_over = 1'b1;
                STEP_V:     lane_ctrl.cap_v = 1'b1;
                STEP_TV:    lane_ctrl.iss = MS_TV;
                STEP_GOAL:  lane_ctrl.cap_goal = 1'b1;
                default:    cap_gain = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= STEP_SETUP;
            m_tvalid_reg <= 1'b0;
            gripping_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
            if (accept)
            begin
                if (s_tuser == CMD_GRIP)
                begin
                    gripping_reg <= 1'b1;
                end
                else if (s_tuser == CMD_RELEASE)
                begin
                    gripping_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_hard_reg  <= GAIN_ONE;
            b_hard_reg  <= GAIN_ONE;
            im_hard_reg <= GAIN_ONE;
            k_soft_reg  <= GAIN_ONE;
            b_soft_reg  <= GAIN_ONE;
            im_soft_reg <= GAIN_ONE;
            t_reg       <= TIME_STEP_DEF;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_K_HARD:    k_hard_reg  <= wr_data;
                REG_B_HARD:    b_hard_reg  <= wr_data;
                REG_IM_HARD:   im_hard_reg <= wr_data;
                REG_K_SOFT:    k_soft_reg  <= wr_data;
                REG_B_SOFT:    b_soft_reg  <= wr_data;
                REG_IM_SOFT:   im_soft_reg <= wr_data;
                REG_TIME_STEP: t_reg       <= wr_data[15:0];
                default:       t_reg       <= t_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_left_reg  <= s_tdata[31:0];
            pos_right_reg <= s_tdata[63:32];
            eff_left_reg  <= s_tdata[95:64];
            eff_right_reg <= s_tdata[127:96];
        end
        if (lane_ctrl.ld_d)
        begin
            rem_reg  <= OBJ_WIDTH_Q - sx35(pos_left_reg) - sx35(pos_right_reg);
            esum_reg <= {1'b0, mag32(eff_left_reg)} + {1'b0, mag32(eff_right_reg)};
        end
        if (cap_gain)
        begin
            hard_reg <= !rem_reg[34] && ({6'd0, esum_reg} > rem20);
        end
    end

    gac_lane u_lane_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .target  (target),
        .pos     (pos_left_reg),
        .eff     (eff_left_reg),
        .k_gain  (k_sel),
        .b_gain  (b_sel),
        .im_gain (im_sel),
        .t_step  (t_reg),
        .goal    (goal_left),
        .vel     (speed_left),
        .sq      (sq_left)
    );

    gac_lane u_lane_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .target  (target),
        .pos     (pos_right_reg),
        .eff     (eff_right_reg),
        .k_gain  (k_sel),
        .b_gain  (b_sel),
        .im_gain (im_sel),
        .t_step  (t_reg),
        .goal    (goal_right),
        .vel     (speed_right),
        .sq      (sq_right)
    );

    gac_merge u_merge (
        .clk         (clk),
        .ctrl        (merge_ctrl),
        .sq_left     (sq_left),
        .sq_right    (sq_right),
        .goal_left   (goal_left),
        .goal_right  (goal_right),
        .speed_left  (speed_left),
        .speed_right (speed_right),
        .hard        (hard_reg),
        .over        (over),
        .tdata       (m_tdata),
        .tuser       (m_tuser)
    );

    assign m_tvalid = m_tvalid_reg;

endmodule
`default_nettype wire

// ===== bench/gripper_admittance_control_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gripper_admittance_control_top_tb
// Self-checking bench for the gripper admittance controller. Control ticks
// go in over the slave stream and goal transfers are checked field by field
// against a Q16.16 model of the tick kept in this bench. The run goes
// through several gain settings, and both stream sides pause at random.
// ----------------------------------------------------------------------------
module gripper_admittance_control_top_tb;
    import gac_pkg::*;

    localparam int unsigned RUN_LIMIT     = 1000000;
    localparam int unsigned DRAIN_CYCLES  = 40;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam logic [1:0]  CMD_RESERVED  = 2'd3;
    localparam logic [2:0]  REG_UNUSED    = 3'd7;
    localparam longint      WIDTH_OBJ     = 3932;
    localparam longint      TARGET_OPEN   = 2621;
    localparam longint      HARDNESS_GAIN = 20;
    localparam bit [63:0]   SD_SQ_LIMIT   = 64'd1288490;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] pl;
        logic signed [31:0] pr;
        logic signed [31:0] el;
        logic signed [31:0] er;
    } tick_t;

    typedef struct packed {
        logic signed [31:0] gpl;
        logic signed [31:0] gpr;
        logic signed [31:0] gvl;
        logic signed [31:0] gvr;
        logic               hard;
    } goal_t;

    typedef struct packed {
        tick_t tick;
        logic  typed;
        goal_t goal;
    } dir_row_t;

    logic           clk;
    logic           rst_n    = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [127:0]   s_tdata  = '0;
    logic [1:0]     s_tuser  = CMD_NONE;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [127:0]   m_tdata;
    logic [0:0]     m_tuser;
    logic           wr_en    = 1'b0;
    logic [2:0]     wr_index = '0;
    logic [31:0]    wr_data  = '0;

    bit [31:0]      gains [0:5] = '{GAIN_ONE, GAIN_ONE, GAIN_ONE,
                                    GAIN_ONE, GAIN_ONE, GAIN_ONE};
    bit [15:0]      time_step_q = TIME_STEP_DEF;
    longint         speed_left  = 0;
    longint         speed_right = 0;
    bit             gripping    = 1'b0;

    goal_t          expected_goals [$];
    int unsigned    mismatch_count = 0;
    int unsigned    cycle_count    = 0;
    int unsigned    send_calm      = 0;
    bit             ready_hold_req = 1'b0;

    dir_row_t dir_rows [0:19] = '{
        '{'{CMD_NONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
          '{32'sd1, 32'sd1, 32'sd52, 32'sd52, 1'b0}},
        '{'{CMD_GRIP, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{CMD_NONE, 32'sd100, -32'sd100, 32'sd655, -32'sd655}, 1'b0, '0},
        '{'{CMD_RELEASE, 32'sd2621, 32'sd2621, 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{CMD_RESERVED, 32'sd1000, 32'sd1000, 32'sd300, 32'sd300}, 1'b0, '0},
        '{'{CMD_GRIP, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{CMD_NONE, 32'sh8000_0000, 32'sh8000_0000, 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{CMD_NONE, 32'sd0, 32'sd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b0, '0},
        '{'{CMD_NONE, 32'sd0, 32'sd0, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, '0},
        '{'{CMD_RELEASE, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
            32'sh7FFF_FFFF}, 1'b0, '0},
        '{'{CMD_NONE, 32'sd1966, 32'sd1966, 32'sd1, 32'sd0}, 1'b0, '0},
        '{'{CMD_NONE, 32'sd1966, 32'sd1966, 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{CMD_NONE, 32'sd1900, 32'sd2000, 32'sd641, 32'sd0}, 1'b0, '0},
        '{'{CMD_NONE, 32'sd1900, 32'sd2000, 32'sd640, 32'sd0}, 1'b0, '0},
        '{'{CMD_GRIP, 32'sd1900, 32'sd2000, -32'sd641, 32'sd0}, 1'b0, '0},
        '{'{CMD_NONE, 32'sd1966, 32'sd1967, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b0, '0},
        '{'{CMD_NONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{CMD_RELEASE, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_3333,
            32'shCCCC_CCCC}, 1'b0, '0},
        '{'{CMD_NONE, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shCCCC_CCCC,
            32'sh3333_3333}, 1'b0, '0},
        '{'{CMD_NONE, 32'sd2621, 32'sd2621, 32'sd0, 32'sd0}, 1'b0, '0}
    };

    gripper_admittance_control_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit [63:0] abs_u64(input longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic longint clamp_s32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // Q16.16 product, rounded to nearest with ties away from zero.
    function automatic longint fx_mul(input longint a, input longint b);
        bit        neg;
        bit [63:0] prod;
        bit [63:0] rnd;
        neg  = (a < 0) != (b < 0);
        prod = abs_u64(a) * abs_u64(b);
        rnd  = (prod + 64'd32768) >> 16;
        if (rnd > 64'h8000_0000)
            rnd = 64'h8000_0000;
        return neg ? clamp_s32(-longint'(rnd)) : clamp_s32(longint'(rnd));
    endfunction

    function automatic void finger_step(input longint pos, input longint eff,
                                        input longint target, input longint k,
                                        input longint b, input longint im,
                                        input longint ts, inout longint vel,
                                        output longint goal, output longint sd);
        longint pos_err;
        longint force_sum;
        longint accel;
        pos_err   = clamp_s32(pos - target);
        sd        = clamp_s32(-fx_mul(k, pos_err) - fx_mul(b, vel));
        force_sum = clamp_s32(sd - eff);
        accel     = fx_mul(im, force_sum);
        vel       = clamp_s32(vel + fx_mul(ts, accel));
        goal      = clamp_s32(pos + fx_mul(ts, vel));
    endfunction

    function automatic void admit_step(input tick_t tk, output bit emit,
                                       output goal_t res);
        longint    pl, pr, el, er, target, rem, esum, k, b, im, ts;
        longint    gl, gr, sdl, sdr;
        bit        hard;
        bit [63:0] sq;
        if (tk.cmd == CMD_GRIP)
            gripping = 1'b1;
        else if (tk.cmd == CMD_RELEASE)
            gripping = 1'b0;
        target = gripping ? 0 : TARGET_OPEN;
        pl   = longint'($signed(tk.pl));
        pr   = longint'($signed(tk.pr));
        el   = longint'($signed(tk.el));
        er   = longint'($signed(tk.er));
        rem  = WIDTH_OBJ - pl - pr;
        esum = longint'(abs_u64(el) + abs_u64(er));
        hard = (rem >= 0) && (esum > HARDNESS_GAIN * rem);
        k    = longint'(hard ? gains[REG_K_HARD] : gains[REG_K_SOFT]);
        b    = longint'(hard ? gains[REG_B_HARD] : gains[REG_B_SOFT]);
        im   = longint'(hard ? gains[REG_IM_HARD] : gains[REG_IM_SOFT]);
        ts   = longint'(time_step_q);
        finger_step(pl, el, target, k, b, im, ts, speed_left, gl, sdl);
        finger_step(pr, er, target, k, b, im, ts, speed_right, gr, sdr);
        sq   = abs_u64(sdl) * abs_u64(sdl) + abs_u64(sdr) * abs_u64(sdr);
        emit = sq > SD_SQ_LIMIT;
        res.gpl  = gl[31:0];
        res.gpr  = gr[31:0];
        res.gvl  = speed_left[31:0];
        res.gvr  = speed_right[31:0];
        res.hard = hard;
    endfunction

    function automatic tick_t random_tick();
        tick_t              tk;
        int unsigned        sel;
        logic signed [31:0] rem;
        sel    = $urandom_range(0, 99);
        tk.cmd = (sel < 60) ? CMD_NONE : (sel < 75) ? CMD_GRIP :
                 (sel < 90) ? CMD_RELEASE : CMD_RESERVED;
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            tk.pl = $urandom;
            tk.pr = $urandom;
        end
        else if (sel < 45)
        begin
            tk.pl = $urandom_range(0, 3932);
            tk.pr = 32'sd3935 - tk.pl - $signed($urandom_range(0, 40));
        end
        else
        begin
            tk.pl = $signed($urandom_range(0, 7000)) - 32'sd1500;
            tk.pr = $signed($urandom_range(0, 7000)) - 32'sd1500;
        end
        rem = 32'sd3932 - tk.pl - tk.pr;
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            tk.el = $urandom;
            tk.er = $urandom;
        end
        else if (sel < 45 && rem >= 0 && rem < 32'sd100000)
        begin
            tk.el = 32'sd20 * rem + $signed($urandom_range(0, 4)) - 32'sd2;
            tk.er = 32'sd0;
            if ($urandom_range(0, 1) != 0)
                tk.el = -tk.el;
            if ($urandom_range(0, 1) != 0)
            begin
                tk.er = tk.el;
                tk.el = 32'sd0;
            end
        end
        else
        begin
            tk.el = $signed($urandom_range(0, 400000)) - 32'sd200000;
            tk.er = $signed($urandom_range(0, 400000)) - 32'sd200000;
        end
        return tk;
    endfunction

    function automatic bit [31:0] rand_gain();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return $urandom_range(0, 32'h0004_0000);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (send_calm != 0)
        begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            send_calm = $urandom_range(10, 50);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 50)
            $display("%0t: %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        if (idx == REG_TIME_STEP)
            time_step_q = value[15:0];
        else if (idx < REG_TIME_STEP)
            gains[idx] = value;
    endtask

    task automatic program_gains(input bit [31:0] kh, input bit [31:0] bh,
                                 input bit [31:0] imh, input bit [31:0] ks,
                                 input bit [31:0] bs, input bit [31:0] ims,
                                 input bit [31:0] ts_word);
        write_reg(REG_K_HARD, kh);
        write_reg(REG_B_HARD, bh);
        write_reg(REG_IM_HARD, imh);
        write_reg(REG_K_SOFT, ks);
        write_reg(REG_B_SOFT, bs);
        write_reg(REG_IM_SOFT, ims);
        write_reg(REG_TIME_STEP, ts_word);
        write_reg(REG_UNUSED, $urandom);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tick(input tick_t tk, input bit typed, input goal_t typed_goal);
        bit          emit;
        goal_t       res;
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {tk.er, tk.el, tk.pr, tk.pl};
        s_tuser  <= tk.cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        admit_step(tk, emit, res);
        if (typed)
            expected_goals = {expected_goals, typed_goal};
        else if (emit)
            expected_goals = {expected_goals, res};
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // A tick that gives no transfer may still be in flight once the queue is
    // empty, so the block is given its full latency before anything changes.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_goals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned stall_left;
        int unsigned steady_left;
        int unsigned hold_left;
        int unsigned r;
        stall_left  = 0;
        steady_left = 0;
        hold_left   = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (ready_hold_req)
            begin
                ready_hold_req = 1'b0;
                hold_left      = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left != 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (steady_left != 0)
            begin
                m_tready <= 1'b1;
                steady_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    steady_left = $urandom_range(5, 40);
                    m_tready <= 1'b1;
                end
                else if (r < 90)
                begin
                    stall_left = $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end
                else
                begin
                    stall_left = $urandom_range(10, 50);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        goal_t got;
        goal_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
                   m_tuser[0]};
            if (expected_goals.size() == 0)
            begin
                report_mismatch("goal transfer with none expected", got.gpl, '0);
            end
            else
            begin
                want = expected_goals.pop_front();
                if (got.gpl !== want.gpl)
                    report_mismatch("goal_position_left", got.gpl, want.gpl);
                if (got.gpr !== want.gpr)
                    report_mismatch("goal_position_right", got.gpr, want.gpr);
                if (got.gvl !== want.gvl)
                    report_mismatch("goal_velocity_left", got.gvl, want.gvl);
                if (got.gvr !== want.gvr)
                    report_mismatch("goal_velocity_right", got.gvr, want.gvr);
                if (got.hard !== want.hard)
                    report_mismatch("hard_gains", 32'(got.hard), 32'(want.hard));
            end
        end
    end

    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("gripper_admittance_control_top test failed");
        $finish;
    end

    initial
    begin
        int row_idx;
        int phase;
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (row_idx = 0; row_idx < $size(dir_rows); row_idx++)
            send_tick(dir_rows[row_idx].tick, dir_rows[row_idx].typed,
                      dir_rows[row_idx].goal);
        for (phase = 0; phase < 7; phase++)
        begin
            wait_drained();
            case (phase)
                0: program_gains('0, '0, '0, '0, '0, '0, '0);
                1: program_gains('1, '1, '1, '1, '1, '1, 32'hFFFF_FFFF);
                2: program_gains(rand_gain(), rand_gain(), '0, rand_gain(), rand_gain(),
                                 rand_gain(), {16'hA5A5, TIME_STEP_DEF});
                6: program_gains(GAIN_ONE, GAIN_ONE, GAIN_ONE, GAIN_ONE, GAIN_ONE,
                                 GAIN_ONE, {16'd0, TIME_STEP_DEF});
                default: program_gains(rand_gain(), rand_gain(), rand_gain(),
                                       rand_gain(), rand_gain(), rand_gain(), $urandom);
            endcase
            if (phase == 3)
                ready_hold_req = 1'b1;
            for (n = 0; n < ((phase == 0) ? 40 : 175); n++)
                send_tick(random_tick(), 1'b0, '0);
        end
        wait_drained();
        if (mismatch_count == 0)
            $display("gripper_admittance_control_top test passed");
        else
            $display("gripper_admittance_control_top test failed");
        $finish;
    end

endmodule
